// ----- design/rwh_pkg.sv -----
`default_nettype none

package rwh_pkg;

	localparam int MAX_WINDOW_DEF = 1024;

	localparam int WSIZE_W = 11;
	localparam int PRIME_W = 31;
	localparam int BASE_W  = 33;
	localparam int BPOW_W  = 31;
	localparam int BYTE_W  = 8;
	localparam int HASH_W  = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 33;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS_PRIME = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_POWER    = 3'd3;

	localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE   = 11'd1;
	localparam logic [PRIME_W-1:0] RST_MODULUS_PRIME = 31'd1999999973;
	localparam logic [BASE_W-1:0]  RST_BASE          = 33'd256;
	localparam logic [BPOW_W-1:0]  RST_BASE_POWER    = 31'd1;

	// Reducer works on a 64-bit dividend, two bits per step, from the top.
	localparam int RED_W     = 64;
	localparam int RED_CNT_W = 5;
	localparam logic [RED_CNT_W-1:0] STEPS_BASE = 5'd17;
	localparam logic [RED_CNT_W-1:0] STEPS_REM  = 5'd20;
	localparam logic [RED_CNT_W-1:0] STEPS_FIN  = 5'd31;

	typedef struct packed {
		logic                 start;
		logic [RED_W-1:0]     dividend;
		logic [RED_CNT_W-1:0] steps;
		logic [PRIME_W-1:0]   modulus;
	} red_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [PRIME_W-1:0] rem;
	} red_rsp_t;

endpackage

`default_nettype wire

// ----- design/rwh_ram.sv -----
`default_nettype none

module rwh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/rwh_modred.sv -----
`default_nettype none

module rwh_modred (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rwh_pkg::red_req_t req,
	output rwh_pkg::red_rsp_t      rsp
);

	import rwh_pkg::*;

	logic [RED_W-1:0]     sh_q;
	logic [PRIME_W-1:0]   r_q;
	logic [PRIME_W-1:0]   p_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [PRIME_W:0] t1, t1m, t2, t2m, pw;

	// Two restoring steps: the remainder stays below p, so 2r+bit stays below 2p.
	always_comb begin
		pw  = {1'b0, p_q};
		t1  = {r_q, sh_q[RED_W-1]};
		t1m = (t1 >= pw) ? t1 - pw : t1;
		t2  = {t1m[PRIME_W-1:0], sh_q[RED_W-2]};
		t2m = (t2 >= pw) ? t2 - pw : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - RED_CNT_W'(1);
			if (cnt_q == RED_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q <= req.dividend;
			r_q  <= '0;
			p_q  <= req.modulus;
		end else if (busy_q) begin
			sh_q <= {sh_q[RED_W-3:0], 2'b00};
			r_q  <= t2m[PRIME_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

endmodule

`default_nettype wire

// ----- design/rolling_window_hash.sv -----
// Rolling Karp-Rabin hash over a sliding window of bytes.
//
// Input channel: in_valid / in_ready carry one in_byte per beat. Output channel:
// out_valid / out_ready carry one hash_value per input beat, in order.
// Configuration: a write with cfg_we high stores cfg_data into the register
// selected by cfg_index (window size, modulus, base, base power). Any write to a
// listed register empties the window and zeroes the hash and position. Write
// only while no byte is in flight; in_ready is low in a cycle with cfg_we high.
//
// One byte at a time, through the shared modular reducer that retires two dividend
// bits per cycle (20 steps to remove the oldest byte, 31 steps for the final
// reduction). The first byte after reset or a configuration write also reduces the
// base once.
//
// Reset brings the registers to their defaults and an empty window. The window
// ring sits in RAM and needs no clearing pass: until the ring wraps the first
// time, the oldest byte reads as zero. A finished hash waits in the output
// register while a new byte is taken; if the receiver still stalls when the next
// hash is done, the block holds it until the output register frees.
`default_nettype none

module rolling_window_hash #(
	parameter int MAX_WINDOW = rwh_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [rwh_pkg::BYTE_W-1:0]        in_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [rwh_pkg::HASH_W-1:0]        hash_value,
	input  wire logic                              cfg_we,
	input  wire logic [rwh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rwh_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import rwh_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WW = $clog2(MAX_WINDOW + 1);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_BMOD_GO   = 4'd1;
	localparam logic [3:0] ST_BMOD_WAIT = 4'd2;
	localparam logic [3:0] ST_MUL1      = 4'd3;
	localparam logic [3:0] ST_RED1_GO   = 4'd4;
	localparam logic [3:0] ST_RED1_WAIT = 4'd5;
	localparam logic [3:0] ST_SUB       = 4'd6;
	localparam logic [3:0] ST_MUL2      = 4'd7;
	localparam logic [3:0] ST_RED2_GO   = 4'd8;
	localparam logic [3:0] ST_RED2_WAIT = 4'd9;
	localparam logic [3:0] ST_FIN       = 4'd10;

	logic [3:0] state_q;

	logic [WSIZE_W-1:0] wsize_q;
	logic [PRIME_W-1:0] prime_q;
	logic [BASE_W-1:0]  base_q;
	logic [BPOW_W-1:0]  bpow_q;

	logic [AW-1:0]      pos_q;
	logic               filled_q;
	logic [HASH_W-1:0]  hash_q;
	logic               bmod_ok_q;
	logic [PRIME_W-1:0] bmod_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [38:0]        prod1_q;
	logic [PRIME_W-1:0] h1_q;
	logic [61:0]        prod2_q;
	logic               out_valid_q;
	logic [HASH_W-1:0]  out_q;

	logic [PRIME_W-1:0] p_eff;
	logic [WW-1:0]      w_eff;
	logic               wrap;
	logic [AW-1:0]      pos_next;
	logic [BYTE_W-1:0]  old_byte;
	logic [BYTE_W-1:0]  ram_rdata;
	logic               in_acc;
	logic               out_free;
	logic               cfg_clear;
	logic [PRIME_W+1:0] sub_sum;
	logic [PRIME_W+1:0] sub_red;

	red_req_t red_req;
	red_rsp_t red_rsp;

	assign p_eff = (prime_q == '0) ? PRIME_W'(1) : prime_q;

	always_comb begin
		if (wsize_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(wsize_q) > 32'(MAX_WINDOW)) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = WW'(wsize_q);
		end
	end

	assign wrap     = (WW'(pos_q) + WW'(1)) >= w_eff;
	assign pos_next = wrap ? '0 : pos_q + AW'(1);

	// The ring fills in slot order from zero, so until it wraps the oldest byte is taken as zero.
	assign old_byte = filled_q ? ram_rdata : '0;

	assign in_ready  = (state_q == ST_IDLE) && !cfg_we;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign hash_value = out_q;

	always_comb begin
		sub_sum = {2'b00, hash_q} + {2'b00, p_eff} - {2'b00, red_rsp.rem};
		sub_red = (sub_sum >= {2'b00, p_eff}) ? sub_sum - {2'b00, p_eff} : sub_sum;
	end

	always_comb begin
		red_req.start    = (state_q == ST_BMOD_GO) || (state_q == ST_RED1_GO)
		                   || (state_q == ST_RED2_GO);
		red_req.modulus  = p_eff;
		red_req.dividend = {prod2_q, 2'b00};
		red_req.steps    = STEPS_FIN;
		case (state_q)
			ST_BMOD_GO: begin
				red_req.dividend = {1'b0, base_q, 30'b0};
				red_req.steps    = STEPS_BASE;
			end
			ST_RED1_GO: begin
				red_req.dividend = {1'b0, prod1_q, 24'b0};
				red_req.steps    = STEPS_REM;
			end
			default: begin
				red_req.dividend = {prod2_q, 2'b00};
				red_req.steps    = STEPS_FIN;
			end
		endcase
	end

	always_comb begin
		cfg_clear = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SIZE, REG_MODULUS_PRIME, REG_BASE, REG_BASE_POWER: begin
					cfg_clear = 1'b1;
				end
				default: begin
					cfg_clear = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= RST_WINDOW_SIZE;
			prime_q <= RST_MODULUS_PRIME;
			base_q  <= RST_BASE;
			bpow_q  <= RST_BASE_POWER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SIZE:   wsize_q <= cfg_data[WSIZE_W-1:0];
				REG_MODULUS_PRIME: prime_q <= cfg_data[PRIME_W-1:0];
				REG_BASE:          base_q  <= cfg_data[BASE_W-1:0];
				REG_BASE_POWER:    bpow_q  <= cfg_data[BPOW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			filled_q    <= 1'b0;
			hash_q      <= '0;
			bmod_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// The user keeps configuration writes to idle; not checked. Input is held off then.
			if (cfg_clear) begin
				pos_q     <= '0;
				filled_q  <= 1'b0;
				hash_q    <= '0;
				bmod_ok_q <= 1'b0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							state_q <= bmod_ok_q ? ST_MUL1 : ST_BMOD_GO;
						end
					end
					ST_BMOD_GO: begin
						state_q <= ST_BMOD_WAIT;
					end
					ST_BMOD_WAIT: begin
						if (red_rsp.done) begin
							bmod_ok_q <= 1'b1;
							state_q   <= ST_MUL1;
						end
					end
					ST_MUL1: begin
						pos_q <= pos_next;
						if (wrap) begin
							filled_q <= 1'b1;
						end
						state_q <= ST_RED1_GO;
					end
					ST_RED1_GO: begin
						state_q <= ST_RED1_WAIT;
					end
					ST_RED1_WAIT: begin
						if (red_rsp.done) begin
							state_q <= ST_SUB;
						end
					end
					ST_SUB: begin
						state_q <= ST_MUL2;
					end
					ST_MUL2: begin
						state_q <= ST_RED2_GO;
					end
					ST_RED2_GO: begin
						state_q <= ST_RED2_WAIT;
					end
					ST_RED2_WAIT: begin
						if (red_rsp.done) begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						if (out_free) begin
							hash_q  <= red_rsp.rem;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q <= in_byte;
		end
		if ((state_q == ST_BMOD_WAIT) && red_rsp.done) begin
			bmod_q <= red_rsp.rem;
		end
		if (state_q == ST_MUL1) begin
			prod1_q <= {31'b0, old_byte} * {8'b0, bpow_q};
		end
		if (state_q == ST_SUB) begin
			h1_q <= sub_red[PRIME_W-1:0];
		end
		if (state_q == ST_MUL2) begin
			prod2_q <= ({31'b0, bmod_q} * {31'b0, h1_q}) + {54'b0, byte_q};
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q <= red_rsp.rem;
		end
	end

	rwh_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_MUL1),
		.waddr (pos_q),
		.wdata (byte_q),
		.re    (in_acc),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	rwh_modred u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (red_req),
		.rsp    (red_rsp)
	);

endmodule

`default_nettype wire

// ----- design/rwh_checker.sv -----
`default_nettype none

module rwh_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [rwh_pkg::BYTE_W-1:0]     in_byte,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [rwh_pkg::HASH_W-1:0]     hash_value,
	input wire logic                           cfg_we,
	input wire logic [rwh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [rwh_pkg::CFG_DATA_W-1:0] cfg_data
);

	import rwh_pkg::*;

	logic [PRIME_W-1:0] prime_q;
	logic [PRIME_W-1:0] p_eff;
	logic [1:0]         pending_q;
	logic               in_acc;
	logic               out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign p_eff   = (prime_q == '0) ? PRIME_W'(1) : prime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q   <= RST_MODULUS_PRIME;
			pending_q <= '0;
		end else begin
			if (cfg_we && (cfg_index == REG_MODULUS_PRIME)) begin
				prime_q <= cfg_data[PRIME_W-1:0];
			end
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_value))
		else $error("hash_value changed while stalled");

	// One byte at a time: an accept closes the input until the hash is done.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while a byte is in flight");

	a_hash_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hash_value < p_eff)
		else $error("hash_value not reduced by the modulus");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result beat without a pending input beat");

	a_in_byte_used: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !$isunknown(in_byte))
		else $error("unknown byte accepted");

endmodule

bind rolling_window_hash rwh_checker u_rwh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_byte    (in_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hash_value (hash_value),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data)
);

`default_nettype wire

// ----- verif/rolling_window_hash_tb.sv -----
`timescale 1ns / 100ps

module rolling_window_hash_tb;
	import rwh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [BASE_W-1:0] BASE_BYTE = 33'd256;
	localparam logic [BASE_W-1:0] BASE_WORD = 33'h1_0000_0000;
	localparam longint unsigned PRIMES [8] = '{2, 3, 251, 257, 65521, 1000003,
		1999999973, 2147483647};
	localparam int N_ITEMS = 1050;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [BYTE_W-1:0] in_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [HASH_W-1:0] hash_value;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the block's registers and window state.
	logic [WSIZE_W-1:0] cur_window;
	logic [PRIME_W-1:0] cur_modulus;
	logic [BASE_W-1:0] cur_base;
	logic [BPOW_W-1:0] cur_bpow;
	bit [BYTE_W-1:0] win_bytes [MAX_WINDOW_DEF];
	int unsigned win_pos;
	longint unsigned win_hash;

	bit [BYTE_W-1:0] bytes_to_send [$];
	bit [HASH_W-1:0] hashes_due [$];
	int n_queued = 0;
	int n_accepted = 0;
	int tx_wait = 0;
	int rx_hold = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int bad_beats = 0;

	rolling_window_hash i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash_value(hash_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic int unsigned eff_window(logic [WSIZE_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_WINDOW_DEF)
			return MAX_WINDOW_DEF;
		return w;
	endfunction

	function automatic longint unsigned mod_pow(longint unsigned b, int unsigned e,
			longint unsigned m);
		longint unsigned r;
		longint unsigned x;
		if (m == 0)
			m = 1;
		r = 1 % m;
		x = b % m;
		while (e > 0) begin
			if (e & 1)
				r = (r * x) % m;
			x = (x * x) % m;
			e = e >> 1;
		end
		return r;
	endfunction

	// Slide the window by one byte and return the new hash.
	function automatic bit [HASH_W-1:0] roll_hash(bit [BYTE_W-1:0] c);
		longint unsigned p;
		longint unsigned oldest;
		longint unsigned cut;
		longint unsigned h;
		longint unsigned b;
		int unsigned w;
		int unsigned k;
		p = (cur_modulus == 0) ? 1 : cur_modulus;
		w = eff_window(cur_window);
		k = (win_pos >= w) ? 0 : win_pos;
		oldest = win_bytes[k];
		cut = (oldest * cur_bpow) % p;
		// Adding p minus the cut keeps the sum non-negative.
		h = (win_hash + (p - cut)) % p;
		b = cur_base % p;
		h = (b * h + c) % p;
		win_hash = h;
		win_bytes[k] = c;
		k++;
		win_pos = (k >= w) ? 0 : k;
		return h[HASH_W-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int width);
		logic [CFG_DATA_W-1:0] mask;
		mask = ({CFG_DATA_W{1'b1}} << width);
		if ($urandom_range(0, 3) == 0)
			return v | ({1'($urandom_range(0, 1)), $urandom()} & mask);
		return v;
	endfunction

	task automatic flag_mismatch(string what, logic [HASH_W-1:0] got,
			logic [HASH_W-1:0] want);
		if (bad_beats < 200)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
		bad_beats++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW_SIZE: cur_window = data[WSIZE_W-1:0];
			REG_MODULUS_PRIME: cur_modulus = data[PRIME_W-1:0];
			REG_BASE: cur_base = data[BASE_W-1:0];
			REG_BASE_POWER: cur_bpow = data[BPOW_W-1:0];
			default: return;
		endcase
		foreach (win_bytes[i])
			win_bytes[i] = '0;
		win_pos = 0;
		win_hash = 0;
	endtask

	task automatic set_config(logic [WSIZE_W-1:0] w, logic [PRIME_W-1:0] p,
			logic [BASE_W-1:0] b, logic [BPOW_W-1:0] bp);
		write_reg(REG_WINDOW_SIZE, with_junk(CFG_DATA_W'(w), WSIZE_W));
		write_reg(REG_MODULUS_PRIME, with_junk(CFG_DATA_W'(p), PRIME_W));
		write_reg(REG_BASE, b);
		write_reg(REG_BASE_POWER, with_junk(CFG_DATA_W'(bp), BPOW_W));
	endtask

	task automatic queue_byte(bit [BYTE_W-1:0] b);
		bytes_to_send.push_back(b);
		n_queued++;
	endtask

	task automatic wait_idle();
		while (!(n_accepted == n_queued && hashes_due.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (bytes_to_send.size() > 0) begin
				in_valid <= 1'b1;
				in_byte <= bytes_to_send.pop_front();
				tx_wait = tx_steady ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!rx_steady)
				rx_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				hashes_due.push_back(roll_hash(in_byte));
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				if (hashes_due.size() == 0)
					flag_mismatch("hash beat with none expected", hash_value, '0);
				else if (hash_value !== hashes_due[0])
					flag_mismatch("hash_value mismatch", hash_value, hashes_due.pop_front());
				else
					void'(hashes_due.pop_front());
			end
		end
	end

	initial begin
		#2000000;
		$display("rolling_window_hash_tb NOT OK");
		$finish;
	end

	initial begin
		int sel;
		int count;
		int unsigned weff;
		logic [WSIZE_W-1:0] w;
		logic [PRIME_W-1:0] p;
		logic [BASE_W-1:0] b;
		logic [BPOW_W-1:0] bp;

		cur_window = RST_WINDOW_SIZE;
		cur_modulus = RST_MODULUS_PRIME;
		cur_base = RST_BASE;
		cur_bpow = RST_BASE_POWER;
		foreach (win_bytes[i])
			win_bytes[i] = '0;
		win_pos = 0;
		win_hash = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Defaults after reset: one-byte window.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h80);
		queue_byte(8'h01);
		wait_idle();

		// Four-byte window that wraps, then writes to unlisted indexes that must
		// leave the window and hash alone.
		set_config(11'd4, 31'd1999999973, BASE_BYTE,
			BPOW_W'(mod_pow(256, 3, 1999999973)));
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		queue_byte(8'h01);
		wait_idle();
		write_reg(REG_SPARE_LO, {CFG_DATA_W{1'b1}});
		write_reg(REG_SPARE_HI, '0);
		queue_byte(8'h7F);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		wait_idle();

		// Window size zero acts as one; modulus zero forces every hash to zero.
		set_config(11'd0, 31'd0, BASE_WORD, 31'h7FFF_FFFE);
		queue_byte(8'hFF);
		queue_byte(8'hAA);
		queue_byte(8'h55);
		wait_idle();

		// Oversized window saturates; base and base power far above the modulus.
		set_config(11'h7FF, 31'd251, {BASE_W{1'b1}}, 31'h7FFF_FFFF);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		wait_idle();

		set_config(11'd3, 31'h7FFF_FFFF, BASE_WORD,
			BPOW_W'(mod_pow(BASE_WORD, 2, 31'h7FFF_FFFF)));
		repeat (6) queue_byte(8'hFF);
		wait_idle();

		while (n_queued < N_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 80)
				w = WSIZE_W'($urandom_range(1, 40));
			else if (sel < 92)
				w = WSIZE_W'($urandom_range(41, 150));
			else if (sel < 96)
				w = WSIZE_W'($urandom_range(151, 1024));
			else if (sel < 98)
				w = WSIZE_W'($urandom_range(1025, 2047));
			else
				w = '0;
			weff = eff_window(w);

			sel = $urandom_range(0, 99);
			if (sel < 70)
				p = PRIME_W'(PRIMES[3'($urandom_range(0, 7))]);
			else if (sel < 76)
				p = PRIME_W'($urandom_range(0, 1));
			else
				p = PRIME_W'($urandom());

			sel = $urandom_range(0, 99);
			if (sel < 40)
				b = BASE_BYTE;
			else if (sel < 70)
				b = BASE_WORD;
			else
				b = {1'($urandom_range(0, 1)), $urandom()};

			if ($urandom_range(0, 99) < 85)
				bp = BPOW_W'(mod_pow(b, weff - 1, p));
			else
				bp = BPOW_W'($urandom());

			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			set_config(w, p, b, bp);
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					{1'($urandom_range(0, 1)), $urandom()});

			count = (weff <= 150) ? 2 * weff + $urandom_range(1, 30) : $urandom_range(20, 40);
			if (count > N_ITEMS - n_queued)
				count = N_ITEMS - n_queued;
			repeat (count) begin
				sel = $urandom_range(0, 9);
				if (sel == 0)
					queue_byte(8'h00);
				else if (sel == 1)
					queue_byte(8'hFF);
				else
					queue_byte(BYTE_W'($urandom_range(0, 255)));
			end
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (bad_beats == 0)
			$display("rolling_window_hash_tb OK");
		else
			$display("rolling_window_hash_tb NOT OK");
		$finish;
	end

endmodule
